>>> design/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned SectorSpan = 60;
  localparam int unsigned FullScale = 255;

  // floor(x / 60) for x up to 255 * 60 is (x * 17477) >> 20
  localparam logic [14:0] DIV60_RECIP = 15'd17477;
  localparam int unsigned DIV60_SHIFT = 20;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // what travels alongside the arithmetic
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  bright;
    logic        grey;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [5:0]  frac;
    logic [7:0]  sat;
  } sec_word_t;

  typedef struct packed {
    meta_t       meta;
    logic [15:0] p_prod;
    logic [15:0] q_prod;
    logic [15:0] t_prod;
  } scl_word_t;

  // floor(y / 255), exact for y up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] acc;
    acc = {1'b0, y} + 17'(y[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

endpackage

>>> design/hsv2rgb_sector.sv
module hsv2rgb_sector (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [8:0]             hue,
  input  logic [7:0]             sat,
  input  logic [7:0]             bright,
  output logic                   out_vld,
  output hsv2rgb_pkg::sec_word_t out_word
);
  import hsv2rgb_pkg::*;

  logic      vld_r;
  sec_word_t word_r;
  sec_word_t word_nxt;
  sector_t   sector;
  logic [8:0] base;
  logic [8:0] frac_full;

  // hue past 359 stays in the last sector but keeps its own fraction
  always_comb begin
    priority if (hue >= 9'(8 * SectorSpan)) begin
      sector = SEC_MAG_RED;
      base   = 9'(8 * SectorSpan);
    end else if (hue >= 9'(7 * SectorSpan)) begin
      sector = SEC_MAG_RED;
      base   = 9'(7 * SectorSpan);
    end else if (hue >= 9'(6 * SectorSpan)) begin
      sector = SEC_MAG_RED;
      base   = 9'(6 * SectorSpan);
    end else if (hue >= 9'(5 * SectorSpan)) begin
      sector = SEC_MAG_RED;
      base   = 9'(5 * SectorSpan);
    end else if (hue >= 9'(4 * SectorSpan)) begin
      sector = SEC_BLU_MAG;
      base   = 9'(4 * SectorSpan);
    end else if (hue >= 9'(3 * SectorSpan)) begin
      sector = SEC_CYN_BLU;
      base   = 9'(3 * SectorSpan);
    end else if (hue >= 9'(2 * SectorSpan)) begin
      sector = SEC_GRN_CYN;
      base   = 9'(2 * SectorSpan);
    end else if (hue >= 9'(SectorSpan)) begin
      sector = SEC_YEL_GRN;
      base   = 9'(SectorSpan);
    end else begin
      sector = SEC_RED_YEL;
      base   = 9'd0;
    end
  end

  assign frac_full = hue - base;

  always_comb begin
    word_nxt.meta.sector = sector;
    word_nxt.meta.bright = bright;
    word_nxt.meta.grey   = (sat == 8'd0);
    word_nxt.frac        = frac_full[5:0];
    word_nxt.sat         = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

>>> design/hsv2rgb_scale.sv
module hsv2rgb_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  hsv2rgb_pkg::sec_word_t in_word,
  output logic                   out_vld,
  output hsv2rgb_pkg::scl_word_t out_word
);
  import hsv2rgb_pkg::*;

  // step a: s*f, s*(60-f), 255-s
  logic        a_vld_r;
  meta_t       a_meta_r;
  logic [13:0] a_sf_r;
  logic [13:0] a_sg_r;
  logic [7:0]  a_pa_r;
  logic [5:0]  rem_frac;
  logic [13:0] a_sf_nxt;
  logic [13:0] a_sg_nxt;
  logic [7:0]  a_pa_nxt;

  // step b: divide by 60, subtract from full scale
  logic        b_vld_r;
  meta_t       b_meta_r;
  logic [7:0]  b_pa_r;
  logic [7:0]  b_qa_r;
  logic [7:0]  b_ta_r;
  logic [28:0] q_recip;
  logic [28:0] t_recip;
  logic [7:0]  b_qa_nxt;
  logic [7:0]  b_ta_nxt;

  // step c: multiply by brightness
  logic        c_vld_r;
  scl_word_t   c_word_r;
  scl_word_t   c_word_nxt;

  assign rem_frac = 6'(SectorSpan) - in_word.frac;
  assign a_sf_nxt = 14'(in_word.sat) * 14'(in_word.frac);
  assign a_sg_nxt = 14'(in_word.sat) * 14'(rem_frac);
  assign a_pa_nxt = 8'(FullScale) - in_word.sat;

  assign q_recip  = 29'(a_sf_r) * 29'(DIV60_RECIP);
  assign t_recip  = 29'(a_sg_r) * 29'(DIV60_RECIP);
  assign b_qa_nxt = 8'(FullScale) - q_recip[DIV60_SHIFT +: 8];
  assign b_ta_nxt = 8'(FullScale) - t_recip[DIV60_SHIFT +: 8];

  always_comb begin
    c_word_nxt.meta   = b_meta_r;
    c_word_nxt.p_prod = 16'(b_meta_r.bright) * 16'(b_pa_r);
    c_word_nxt.q_prod = 16'(b_meta_r.bright) * 16'(b_qa_r);
    c_word_nxt.t_prod = 16'(b_meta_r.bright) * 16'(b_ta_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_meta_r <= in_word.meta;
    a_sf_r   <= a_sf_nxt;
    a_sg_r   <= a_sg_nxt;
    a_pa_r   <= a_pa_nxt;
    b_meta_r <= a_meta_r;
    b_pa_r   <= a_pa_r;
    b_qa_r   <= b_qa_nxt;
    b_ta_r   <= b_ta_nxt;
    c_word_r <= c_word_nxt;
  end

  assign out_vld  = c_vld_r;
  assign out_word = c_word_r;

endmodule

>>> design/hsv2rgb_mix.sv
module hsv2rgb_mix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  hsv2rgb_pkg::scl_word_t in_word,
  output logic                   out_vld,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue
);
  import hsv2rgb_pkg::*;

  logic       vld_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;
  logic [7:0] p_lvl;
  logic [7:0] q_lvl;
  logic [7:0] t_lvl;
  logic [7:0] v_lvl;

  assign p_lvl = div255(in_word.p_prod);
  assign q_lvl = div255(in_word.q_prod);
  assign t_lvl = div255(in_word.t_prod);
  assign v_lvl = in_word.meta.bright;

  always_comb begin
    if (in_word.meta.grey) begin
      red_nxt   = v_lvl;
      green_nxt = v_lvl;
      blue_nxt  = v_lvl;
    end else begin
      unique case (in_word.meta.sector)
        SEC_RED_YEL: begin
          red_nxt = v_lvl; green_nxt = t_lvl; blue_nxt = p_lvl;
        end
        SEC_YEL_GRN: begin
          red_nxt = q_lvl; green_nxt = v_lvl; blue_nxt = p_lvl;
        end
        SEC_GRN_CYN: begin
          red_nxt = p_lvl; green_nxt = v_lvl; blue_nxt = t_lvl;
        end
        SEC_CYN_BLU: begin
          red_nxt = p_lvl; green_nxt = q_lvl; blue_nxt = v_lvl;
        end
        SEC_BLU_MAG: begin
          red_nxt = t_lvl; green_nxt = p_lvl; blue_nxt = v_lvl;
        end
        default: begin
          red_nxt = v_lvl; green_nxt = p_lvl; blue_nxt = q_lvl;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_vld = vld_r;
  assign red     = red_r;
  assign green   = green_r;
  assign blue    = blue_r;

endmodule

>>> design/hsv_to_rgb_converter.sv
// channel   ports                                         direction
// input     start, busy, in_hue, in_saturation,
//           in_brightness                                 in (busy out)
// result    out_valid, out_red, out_green, out_blue       out
//
// five register stages: sector split, s*f products, divide by 60,
// brightness products, divide by 255 and channel select
// one word per clock; out_valid follows start through the five register stages
// busy is always low since the receiver cannot stall and nothing backs up
// synchronous active-low reset clears the valid bits only
module hsv_to_rgb_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [8:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import hsv2rgb_pkg::*;

  logic      accept;
  logic      sec_vld;
  sec_word_t sec_word;
  logic      scl_vld;
  scl_word_t scl_word;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  hsv2rgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .hue      (in_hue),
    .sat      (in_saturation),
    .bright   (in_brightness),
    .out_vld  (sec_vld),
    .out_word (sec_word)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sec_vld),
    .in_word  (sec_word),
    .out_vld  (scl_vld),
    .out_word (scl_word)
  );

  hsv2rgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (scl_vld),
    .in_word  (scl_word),
    .out_vld  (out_valid),
    .red      (out_red),
    .green    (out_green),
    .blue     (out_blue)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted word did not come out after five cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result strobe without a matching accepted word");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_saturation, 5) == 8'd0) |->
      (out_red == out_green && out_green == out_blue))
    else $error("zero saturation did not give grey");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == $past(in_brightness, 5) ||
                   out_green == $past(in_brightness, 5) ||
                   out_blue == $past(in_brightness, 5)))
    else $error("no channel carries the brightness level");

endmodule
